FILE: design/sbr_pkg.sv
// Shared types, constants and register codes for the shear remap block.
// No dependencies; imported by sbr_div and shear_bilinear_remap.
package sbr_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_FRAC_BITS  = 12;

  // shear factors are Q4.12
  localparam int SHEAR_FRAC = 12;
  localparam int DET_W      = 32;   // signed determinant, Q24
  localparam int DABS_W     = 31;   // magnitude of the determinant
  localparam int SIZE_W     = 13;   // saturated image size, at most 2047
  localparam int CRD_W      = 14;   // doubled centred coordinates

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_COLOR_MODE   = 3'd2;
  localparam logic [2:0] REG_SHEAR_H      = 3'd3;
  localparam logic [2:0] REG_SHEAR_V      = 3'd4;

  localparam logic CMD_LOAD = 1'b0;

  localparam logic [1:0] STAT_INSIDE   = 2'd0;
  localparam logic [1:0] STAT_OUTSIDE  = 2'd1;
  localparam logic [1:0] STAT_SINGULAR = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [9:0] pixel_row;
    logic [9:0] pixel_col;
    logic [7:0] in_chan0;
    logic [7:0] in_chan1;
    logic [7:0] in_chan2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic [1:0] status;
  } out_item_t;

  // request travelling down the pipeline
  typedef struct packed {
    logic        valid;
    logic        is_load;
    logic [1:0]  status;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [23:0] px;
  } item_t;

endpackage

FILE: design/sbr_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes (v and w).
// Depends on sbr_pkg. Divisor is held steady by the caller while requests flow.
module sbr_div #(
  parameter int QB = $clog2(sbr_pkg::DEF_MAX_WIDTH) + sbr_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [sbr_pkg::DABS_W-1:0]  divisor,
  input  sbr_pkg::item_t              in_item,
  input  logic [sbr_pkg::DABS_W+QB-1:0] in_rv,
  input  logic [sbr_pkg::DABS_W+QB-1:0] in_rw,
  output sbr_pkg::item_t              out_item,
  output logic [QB-1:0]               out_qv,
  output logic [QB-1:0]               out_qw
);
  import sbr_pkg::*;

  localparam int RW = DABS_W + QB;

  item_t         st_item [QB+1];
  logic [RW-1:0] st_rv   [QB+1];
  logic [RW-1:0] st_rw   [QB+1];
  logic [QB-1:0] st_qv   [QB+1];
  logic [QB-1:0] st_qw   [QB+1];

  assign st_item[0] = in_item;
  assign st_rv[0]   = in_rv;
  assign st_rw[0]   = in_rw;
  assign st_qv[0]   = '0;
  assign st_qw[0]   = '0;

  // remainder enters below divisor << QB, so each stage settles one bit
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int BIT = QB - 1 - k;
    logic [RW-1:0] dsh;
    logic [RW:0]   tv;
    logic [RW:0]   tw;

    assign dsh = RW'(divisor) << BIT;
    assign tv  = {1'b0, st_rv[k]} - {1'b0, dsh};
    assign tw  = {1'b0, st_rw[k]} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_item[k+1].valid <= 1'b0;
      end else if (adv) begin
        st_item[k+1] <= st_item[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_rv[k+1] <= tv[RW] ? st_rv[k] : tv[RW-1:0];
        st_rw[k+1] <= tw[RW] ? st_rw[k] : tw[RW-1:0];
        st_qv[k+1] <= st_qv[k] | (QB'(!tv[RW]) << BIT);
        st_qw[k+1] <= st_qw[k] | (QB'(!tw[RW]) << BIT);
      end
    end
  end

  assign out_item = st_item[QB];
  assign out_qv   = st_qv[QB];
  assign out_qw   = st_qw[QB];

endmodule

FILE: design/shear_bilinear_remap.sv
// Shear inversion with bilinear resampling over a banked frame store.
// Depends on sbr_pkg and sbr_div.
//
// Load requests write one pixel into the frame store; query requests return one
// resampled pixel and a status. One request is taken every clock unless a result
// blocked at the output stalls the pipeline. The source point is formed by a
// bit-per-stage divider whose quotients are QB bits wide, where QB is
// max(clog2(MAX_WIDTH), clog2(MAX_HEIGHT)) + FRAC_BITS.
// The store is split into four banks by row and column parity so the four
// neighbours of a point are read in the same cycle. Loads travel the same
// pipeline and write at the read stage, so queries see every earlier load.
// The store is not cleared: reading a pixel never loaded gives undefined data.
// Registers may only be written while no request is in flight.
module shear_bilinear_remap #(
  parameter int MAX_WIDTH  = sbr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbr_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = sbr_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sbr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sbr_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sbr_pkg::*;

  localparam int CB   = $clog2(MAX_WIDTH);
  localparam int RB   = $clog2(MAX_HEIGHT);
  localparam int HCB  = (CB > 1) ? CB - 1 : 1;
  localparam int HRB  = (RB > 1) ? RB - 1 : 1;
  localparam int AB   = HCB + HRB;
  localparam int DEPTH = 1 << AB;
  localparam int LXC  = (CB > 10) ? CB : 10;
  localparam int LXR  = (RB > 10) ? RB : 10;
  localparam int QB   = ((CB > RB) ? CB : RB) + FRAC_BITS;
  localparam int RW   = DABS_W + QB;
  localparam int NB   = 47 + FRAC_BITS;
  localparam int XW   = ((NB > RW) ? NB : RW) + 1;
  localparam int WW   = 2 * FRAC_BITS + 2;
  localparam int PW   = WW + 8;
  localparam int SW   = 2 * FRAC_BITS + 10;
  localparam int PD_W = SIZE_W + DET_W + 1;

  localparam logic [SIZE_W-1:0] MAXW_S = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAXH_S = SIZE_W'(MAX_HEIGHT);
  localparam logic signed [DET_W-1:0] DET_ONE = DET_W'(64'd1 << (2 * SHEAR_FRAC));
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // ---------------- configuration ----------------
  logic [10:0]        image_width;
  logic [10:0]        image_height;
  logic               color_mode;
  logic signed [15:0] shear_h;
  logic signed [15:0] shear_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
      color_mode   <= 1'b1;
      shear_h      <= '0;
      shear_v      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[10:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        REG_SHEAR_H:      shear_h      <= $signed(cfg_data);
        REG_SHEAR_V:      shear_v      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // values derived from the registers, recomputed in registers after a write
  logic [SIZE_W-1:0]       wsat;
  logic [SIZE_W-1:0]       hsat;
  logic [QB-1:0]           limv;
  logic [QB-1:0]           limh;
  logic signed [DET_W-1:0] sprod;
  logic signed [DET_W-1:0] det;
  logic                    dneg;
  logic                    dzero;
  logic [DABS_W-1:0]       dabs;

  always_ff @(posedge clk) begin
    wsat <= (image_width == 11'd0) ? SIZE_W'(1) :
            ((SIZE_W'(image_width) > MAXW_S) ? MAXW_S : SIZE_W'(image_width));
    hsat <= (image_height == 11'd0) ? SIZE_W'(1) :
            ((SIZE_W'(image_height) > MAXH_S) ? MAXH_S : SIZE_W'(image_height));
    limv  <= QB'({wsat - SIZE_W'(1), {FRAC_BITS{1'b0}}});
    limh  <= QB'({hsat - SIZE_W'(1), {FRAC_BITS{1'b0}}});
    sprod <= shear_h * shear_v;
    det   <= DET_ONE - sprod;
    dneg  <= det[DET_W-1];
    dzero <= (det == '0);
    dabs  <= DABS_W'(det[DET_W-1] ? -det : det);
  end

  // ---------------- flow control ----------------
  item_t e_item;
  logic  last_res;
  logic  adv;
  logic  acc;

  assign last_res = e_item.valid && !e_item.is_load;
  assign adv      = !out_valid || out_ready || !last_res;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  // ---------------- stage 0: capture ----------------
  item_t s0, s0_next;

  always_comb begin
    s0_next.valid   = acc;
    s0_next.is_load = (in_data.cmd == CMD_LOAD);
    s0_next.status  = STAT_INSIDE;
    s0_next.row     = in_data.pixel_row;
    s0_next.col     = in_data.pixel_col;
    s0_next.px      = color_mode ? {in_data.in_chan2, in_data.in_chan1, in_data.in_chan0}
                                 : {16'd0, in_data.in_chan0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else if (adv) begin
      s0 <= s0_next;
    end
  end

  // ---------------- stages 1..6: numerators and range checks ----------------
  item_t s1, s2, s3, s4, s5, s6;
  item_t s5_next, s6_next;

  logic signed [CRD_W-1:0]       u2_1, t2_1, u2_2, t2_2;
  logic signed [29:0]            sxt, syu;
  logic signed [PD_W-1:0]        pwd, phd, pwd3, phd3;
  logic signed [DET_W-1:0]       na, nb;
  logic signed [NB-1:0]          nv4, nw4, nv5, nw5;
  logic [RW-1:0]                 rv6, rw6;
  logic [RW-1:0]                 dlim;
  logic                          outside6;
  logic [1:0]                    s6_status;

  assign dlim     = {dabs, {QB{1'b0}}};
  assign outside6 = nv5[NB-1] || nw5[NB-1] ||
                    (XW'($unsigned(nv5)) >= XW'(dlim)) ||
                    (XW'($unsigned(nw5)) >= XW'(dlim));
  assign s6_status = (s5.status == STAT_INSIDE && outside6) ? STAT_OUTSIDE : s5.status;

  always_comb begin
    s5_next        = s4;
    s5_next.status = dzero ? STAT_SINGULAR : s4.status;
    s6_next        = s5;
    s6_next.status = s6_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      s5.valid <= 1'b0;
      s6.valid <= 1'b0;
    end else if (adv) begin
      s1 <= s0;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
      s5 <= s5_next;
      s6 <= s6_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u2_1 <= $signed({3'b000, s0.col, 1'b0}) - $signed({1'b0, wsat});
      t2_1 <= $signed({1'b0, hsat}) - $signed({3'b000, s0.row, 1'b0});
      sxt  <= shear_h * t2_1;
      syu  <= shear_v * u2_1;
      pwd  <= $signed({1'b0, wsat}) * det;
      phd  <= $signed({1'b0, hsat}) * det;
      u2_2 <= u2_1;
      t2_2 <= t2_1;
      na   <= (DET_W'(u2_2) <<< SHEAR_FRAC) - DET_W'(sxt);
      nb   <= (DET_W'(t2_2) <<< SHEAR_FRAC) - DET_W'(syu);
      pwd3 <= pwd;
      phd3 <= phd;
      nv4  <= (NB'(na) <<< (SHEAR_FRAC - 1 + FRAC_BITS)) + (NB'(pwd3) <<< (FRAC_BITS - 1));
      nw4  <= (NB'(phd3) <<< (FRAC_BITS - 1)) - (NB'(nb) <<< (SHEAR_FRAC - 1 + FRAC_BITS));
      nv5  <= dneg ? -nv4 : nv4;
      nw5  <= dneg ? -nw4 : nw4;
      rv6  <= RW'($unsigned(nv5));
      rw6  <= RW'($unsigned(nw5));
    end
  end

  // ---------------- divider ----------------
  item_t         dq_item;
  logic [QB-1:0] qv, qw;

  sbr_div #(
    .QB(QB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .divisor  (dabs),
    .in_item  (s6),
    .in_rv    (rv6),
    .in_rw    (rw6),
    .out_item (dq_item),
    .out_qv   (qv),
    .out_qw   (qw)
  );

  // ---------------- stage a: neighbour coordinates ----------------
  item_t                a_item, a_next;
  logic [FRAC_BITS-1:0] pv_a, pw_a;
  logic [CB-1:0]        left_a, right_a;
  logic [RB-1:0]        top_a, bot_a;
  logic                 oob;

  assign oob = (qv > limv) || (qw > limh);

  always_comb begin
    a_next        = dq_item;
    a_next.status = (dq_item.status == STAT_INSIDE && oob) ? STAT_OUTSIDE
                                                            : dq_item.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_item.valid <= 1'b0;
    end else if (adv) begin
      a_item <= a_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pv_a    <= qv[FRAC_BITS-1:0];
      pw_a    <= qw[FRAC_BITS-1:0];
      left_a  <= CB'(qv >> FRAC_BITS);
      right_a <= CB'(qv >> FRAC_BITS) + CB'(qv[FRAC_BITS-1:0] != '0);
      top_a   <= RB'(qw >> FRAC_BITS);
      bot_a   <= RB'(qw >> FRAC_BITS) + RB'(qw[FRAC_BITS-1:0] != '0);
    end
  end

  // ---------------- frame store: four parity banks ----------------
  logic [LXR-1:0] ld_row;
  logic [LXC-1:0] ld_col;
  logic [1:0]     wbank;
  logic [AB-1:0]  waddr;
  logic           we;
  logic [23:0]    rdata [4];

  assign ld_row = LXR'(a_item.row);
  assign ld_col = LXC'(a_item.col);
  assign wbank  = {ld_row[0], ld_col[0]};
  assign waddr  = {HRB'(ld_row >> 1), HCB'(ld_col >> 1)};
  assign we     = adv && a_item.valid && a_item.is_load &&
                  (SIZE_W'(a_item.row) < MAXH_S) && (SIZE_W'(a_item.col) < MAXW_S);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BSEL = 2'(b);
    logic [23:0]   mem [DEPTH];
    logic [RB-1:0] rsel;
    logic [CB-1:0] csel;
    logic [AB-1:0] raddr;

    assign rsel  = (top_a[0] == BSEL[1]) ? top_a : bot_a;
    assign csel  = (left_a[0] == BSEL[0]) ? left_a : right_a;
    assign raddr = {HRB'(rsel >> 1), HCB'(csel >> 1)};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (we && wbank == BSEL) begin
          mem[waddr] <= a_item.px;
        end
        rdata[b] <= mem[raddr];
      end
    end
  end

  // ---------------- stage b: read data arrives ----------------
  item_t                b_item;
  logic [FRAC_BITS-1:0] pv_b, pw_b;
  logic                 tpar, lpar;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_item.valid <= 1'b0;
    end else if (adv) begin
      b_item <= a_item;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pv_b <= pv_a;
      pw_b <= pw_a;
      tpar <= top_a[0];
      lpar <= left_a[0];
    end
  end

  // ---------------- stage c: weights, unscrambled pixels ----------------
  item_t             c_item;
  logic [FRAC_BITS:0] om_pv, om_pw;
  logic [WW-1:0]     w00, w01, w10, w11;
  logic [23:0]       p00, p01, p10, p11;
  logic              rstep, cstep;

  assign om_pv = ONE - {1'b0, pv_b};
  assign om_pw = ONE - {1'b0, pw_b};
  // a zero fraction keeps the neighbour on the same row or column
  assign rstep = (pw_b != '0);
  assign cstep = (pv_b != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_item.valid <= 1'b0;
    end else if (adv) begin
      c_item <= b_item;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w00 <= WW'(om_pw) * WW'(om_pv);
      w01 <= WW'(om_pw) * WW'(pv_b);
      w10 <= WW'(pw_b) * WW'(om_pv);
      w11 <= WW'(pw_b) * WW'(pv_b);
      p00 <= rdata[{tpar, lpar}];
      p01 <= rdata[{tpar, lpar ^ cstep}];
      p10 <= rdata[{tpar ^ rstep, lpar}];
      p11 <= rdata[{tpar ^ rstep, lpar ^ cstep}];
    end
  end

  // ---------------- stage d: weighted channel products ----------------
  item_t         d_item;
  logic [PW-1:0] pr [3][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_item.valid <= 1'b0;
    end else if (adv) begin
      d_item <= c_item;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        pr[ch][0] <= PW'(w00) * PW'(p00[8*ch +: 8]);
        pr[ch][1] <= PW'(w01) * PW'(p01[8*ch +: 8]);
        pr[ch][2] <= PW'(w10) * PW'(p10[8*ch +: 8]);
        pr[ch][3] <= PW'(w11) * PW'(p11[8*ch +: 8]);
      end
    end
  end

  // ---------------- stage e: sums, truncation, masking ----------------
  logic [SW-1:0] sum_c [3];
  logic [7:0]    e_ch  [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = SW'(pr[ch][0]) + SW'(pr[ch][1]) + SW'(pr[ch][2]) + SW'(pr[ch][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_item.valid <= 1'b0;
    end else if (adv) begin
      e_item <= d_item;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        e_ch[ch] <= (d_item.status != STAT_INSIDE || (ch != 0 && !color_mode)) ? 8'd0
                    : sum_c[ch][2*FRAC_BITS +: 8];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      if (last_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_res) begin
      out_data.out_chan0 <= e_ch[0];
      out_data.out_chan1 <= e_ch[1];
      out_data.out_chan2 <= e_ch[2];
      out_data.status    <= e_item.status;
    end
  end

  // ---------------- checks ----------------
  a_zero_when_not_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STAT_INSIDE |->
      out_data.out_chan0 == 8'd0 && out_data.out_chan1 == 8'd0 && out_data.out_chan2 == 8'd0)
    else $error("nonzero pixel with outside or singular status");

  a_gray_channels: assert property (@(posedge clk) disable iff (rst)
    out_valid && !color_mode |-> out_data.out_chan1 == 8'd0 && out_data.out_chan2 == 8'd0)
    else $error("gray mode result carries color channels");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && last_res |=> $stable(e_item))
    else $error("pipeline tail moved while result was blocked");

endmodule
